/* src/upd_pkg.sv */
// shared types and constants for the url percent decoder
package upd_pkg;

  localparam int UPD_QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  // one queue entry holds every decoded byte that one input word yields
  typedef struct packed {
    logic       two;    // second byte valid
    logic [7:0] b0;     // first byte out
    logic [7:0] b1;     // second byte out
    logic       last;   // entry comes from the final input word
  } upd_entry_t;

  typedef struct packed {
    logic       push;
    upd_entry_t entry;
  } upd_push_t;

endpackage

/* src/upd_front.sv */
// front end: escape tracking and classification of each input byte
module upd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output upd_pkg::upd_push_t push
);
  import upd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held_digit, held_digit_next;

  logic       is_digit, is_hex;
  logic       accept;
  logic [7:0] plain_val;
  logic       plain_emit;
  logic       plain_pct;
  upd_entry_t entry;
  logic       emit;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  assign accept   = in_valid && in_ready;
  assign is_digit = in_byte inside {[8'h30:8'h39]};
  assign is_hex   = is_digit || (in_byte inside {[8'h61:8'h66]})
                             || (in_byte inside {[8'h41:8'h46]});

  // handling of a byte outside any escape
  always_comb begin
    plain_pct  = 1'b0;
    plain_emit = 1'b1;
    plain_val  = in_byte;
    if (in_byte == CH_PLUS) begin
      plain_val = CH_SPACE;
    end else if (in_byte == CH_PERCENT) begin
      plain_emit = 1'b0;
      plain_pct  = 1'b1;
    end
  end

  always_comb begin
    phase_next      = PH_IDLE;
    held_digit_next = held_digit;
    entry.two       = 1'b0;
    entry.b0        = plain_val;
    entry.b1        = plain_val;
    entry.last      = in_last;
    emit            = plain_emit;
    case (phase)
      PH_DIGIT: begin
        emit = 1'b1;
        if (is_hex) begin
          entry.b0 = {hex_val(held_digit), hex_val(in_byte)};
        end else begin
          // broken escape: held digit goes out as is, then the byte unless it opens a new escape
          entry.b0  = held_digit;
          entry.two = plain_emit;
          if (plain_pct) begin
            phase_next = PH_PCT;
          end
        end
      end
      PH_PCT: begin
        if (is_hex && !in_last) begin
          held_digit_next = in_byte;
          phase_next      = PH_DIGIT;
          emit            = 1'b0;
        end else if (plain_pct) begin
          phase_next = PH_PCT;
        end
      end
      default: begin
        if (plain_pct) begin
          phase_next = PH_PCT;
        end
      end
    endcase
    if (in_last) begin
      phase_next      = PH_IDLE;
      held_digit_next = 8'h00;
    end
  end

  assign push.push  = accept && emit;
  assign push.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= 8'h00;
    end else if (accept) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

endmodule

/* src/upd_queue.sv */
// short queue of decoded entries between front and back
module upd_queue #(
  parameter int DEPTH = upd_pkg::UPD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  upd_pkg::upd_push_t push,
  output logic               not_full,
  output logic               head_valid,
  output upd_pkg::upd_entry_t head,
  input  logic               pop
);
  import upd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upd_entry_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count, count_next;
  logic          do_push, do_pop;

  assign not_full   = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push.push && not_full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + CW'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push.push |-> not_full)
    else $error("entry pushed while queue full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow a push");
`endif

endmodule

/* src/upd_back.sv */
// back end: sends the one or two bytes of each queue entry as words
module upd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  upd_pkg::upd_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                string_end
);
  import upd_pkg::*;

  logic sel, sel_next;
  logic fire, final_word;

  assign out_valid  = head_valid;
  assign fire       = out_valid && out_ready;
  assign final_word = !head.two || sel;
  assign out_byte   = sel ? head.b1 : head.b0;
  assign run_last   = final_word;
  assign string_end = final_word && head.last;
  assign pop        = fire && final_word;

  always_comb begin
    sel_next = sel;
    if (fire) begin
      sel_next = !final_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else begin
      sel <= sel_next;
    end
  end

endmodule

/* src/url_percent_decoder_top.sv */
// top level of the url percent decoder: front, queue and back joined
// a decoded byte is registered in the queue before it is offered
// throughput: one input word per cycle while the queue is not full; a word
// that yields two bytes goes out as two output words and can stall the input
// words that yield no byte (a percent sign or first hex digit) emit nothing
// reset (rst, synchronous) clears the escape phase, the queue and the back end
module url_percent_decoder_top #(
  parameter int QUEUE_DEPTH = upd_pkg::UPD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_last
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // run_last
  output logic       m_tuser    // [0] string_end
);
  import upd_pkg::*;

  upd_push_t  push;
  upd_entry_t head;
  logic       not_full, head_valid, pop;

  assign s_tready = not_full;

  upd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .push     (push)
  );

  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .not_full   (not_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .run_last   (m_tlast),
    .string_end (m_tuser)
  );

endmodule

/* test/tb_url_percent_decoder_top.sv */
// self-checking testbench for the url percent decoder top level
module tb_url_percent_decoder_top;
  import upd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_HIGH} esc_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       str_end;
  } dec_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  // decoder copy used for prediction
  esc_phase_t esc_phase = PH_IDLE;
  logic [7:0] held_digit = 8'h00;
  dec_word_t  decoded_q[$];
  logic [7:0] text_q[$];

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_gap_left = 0;

  int cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int strings_sent = 0;
  int bytes_checked = 0;
  dec_word_t got_w;
  dec_word_t want_w;

  url_percent_decoder_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] lc;
    if (c <= "9")
      return 4'(c - "0");
    lc = c | 8'h20;
    return 4'(lc - "a" + 8'd10);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 10)
      return "0" + v;
    if ($urandom_range(0, 1) == 0)
      return "a" + v - 8'd10;
    return "A" + v - 8'd10;
  endfunction

  // expected decoded bytes for one accepted input word
  task automatic decode_word(input logic [7:0] b, input logic is_last);
    logic [7:0] res [0:1];
    int n;
    logic as_plain;
    dec_word_t w;
    n = 0;
    as_plain = 1'b0;
    if (esc_phase == PH_HIGH) begin
      esc_phase = PH_IDLE;
      if (is_hex(b)) begin
        res[n] = {nibble(held_digit), nibble(b)};
        n++;
      end else begin
        // broken second digit: held digit goes out as a plain byte
        res[n] = held_digit;
        n++;
        as_plain = 1'b1;
      end
    end else if (esc_phase == PH_PCT) begin
      esc_phase = PH_IDLE;
      if (is_hex(b) && !is_last) begin
        held_digit = b;
        esc_phase = PH_HIGH;
      end else begin
        as_plain = 1'b1;
      end
    end else begin
      esc_phase = PH_IDLE;
      as_plain = 1'b1;
    end
    if (as_plain) begin
      if (b == CH_PLUS) begin
        res[n] = CH_SPACE;
        n++;
      end else if (b == CH_PERCENT) begin
        esc_phase = is_last ? PH_IDLE : PH_PCT;
      end else begin
        res[n] = b;
        n++;
      end
    end
    if (is_last) begin
      esc_phase = PH_IDLE;
      held_digit = 8'h00;
    end
    for (int i = 0; i < n; i++) begin
      w.data = res[i];
      w.run_last = (i == n - 1);
      w.str_end = (i == n - 1) && is_last;
      decoded_q.push_back(w);
    end
  endtask

  task automatic push_word(input logic [7:0] b, input logic is_last);
    int gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= is_last;
    do @(posedge clk); while (!s_tready);
    decode_word(b, is_last);
    words_sent++;
  endtask

  task automatic send_text_q();
    for (int i = 0; i < text_q.size(); i++)
      push_word(text_q[i], i == text_q.size() - 1);
    strings_sent++;
  endtask

  task automatic send_text(input string txt);
    text_q.delete();
    for (int i = 0; i < txt.len(); i++)
      text_q.push_back(txt[i]);
    send_text_q();
  endtask

  // well-formed escapes mixed with plus signs, lone percent signs, broken escapes and raw bytes
  task automatic gen_string();
    int len;
    logic [7:0] c;
    text_q.delete();
    len = $urandom_range(1, 10);
    while (text_q.size() < len) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          text_q.push_back(CH_PERCENT);
          text_q.push_back(rand_hex_char());
          text_q.push_back(rand_hex_char());
        end
        4: text_q.push_back(CH_PLUS);
        5: text_q.push_back(CH_PERCENT);
        6: begin
          text_q.push_back(CH_PERCENT);
          text_q.push_back(rand_hex_char());
          c = 8'($urandom_range(0, 255));
          text_q.push_back(is_hex(c) ? "g" : c);
        end
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    send_text("a+%41");
    send_text("%4a%4F");
    send_text("%z%4z");
    send_text("%%4+");
    send_text("b%");
    send_text("%4");
    text_q.delete();
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    send_text_q();
    wait_drain();
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = words_sent + 450;
    while (words_sent < stop_at) begin
      gen_string();
      send_text_q();
    end
    wait_drain();
  endtask

  // output held off for a long time while input keeps coming
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_reqs++;
    repeat (4) begin
      gen_string();
      send_text_q();
    end
    send_text("%41%42+%4x%43");
    wait_drain();
  endtask

  task automatic test_streaming();
    int stop_at;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    stop_at = words_sent + 60;
    while (words_sent < stop_at) begin
      gen_string();
      send_text_q();
    end
    wait_drain();
  endtask

  // receiver: random stall bursts plus a requested long hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_gap_left = $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_w.data = m_tdata;
      got_w.run_last = m_tlast;
      got_w.str_end = m_tuser;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: byte %h run_last %b string_end %b",
                   got_w.data, got_w.run_last, got_w.str_end);
      end else begin
        want_w = decoded_q.pop_front();
        bytes_checked++;
        if (got_w.data !== want_w.data || got_w.run_last !== want_w.run_last ||
            got_w.str_end !== want_w.str_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h/%b/%b got %h/%b/%b (byte/run_last/string_end)",
                     want_w.data, want_w.run_last, want_w.str_end,
                     got_w.data, got_w.run_last, got_w.str_end);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    test_streaming();
    $display("covered %0d strings, %0d input words, %0d decoded bytes checked",
             strings_sent, words_sent, bytes_checked);
    $display("mix of plus signs, good and broken escapes, high bytes and a long output stall");
    if (mismatches == 0 && decoded_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* url_percent_decoder_top.f */
src/upd_pkg.sv
src/upd_front.sv
src/upd_queue.sv
src/upd_back.sv
src/url_percent_decoder_top.sv
test/tb_url_percent_decoder_top.sv
